FILE: src/bcpy_pkg.sv
// Package with shared constants, types and field layout for the bit offset block copy.
`timescale 1ns / 1ps

package bcpy_pkg;

	localparam int STORE_BYTES = 256;
	localparam int SADDR_W     = $clog2(STORE_BYTES);
	localparam int BIDX_W      = SADDR_W + 3;
	localparam int CNT_W       = BIDX_W + 1;
	localparam int SPTR_W      = SADDR_W + 2;
	localparam int TOTAL_BITS  = STORE_BYTES * 8;

	localparam int MODE_W      = 2;
	localparam int BYTE_W      = 8;

	localparam int ADDR_LO     = 0;
	localparam int DATA_LO     = ADDR_LO + SADDR_W;
	localparam int SIDX_LO     = DATA_LO + BYTE_W;
	localparam int DIDX_LO     = SIDX_LO + BIDX_W;
	localparam int CNT_LO      = DIDX_LO + BIDX_W;
	localparam int IN_USED_W   = CNT_LO + CNT_W;
	localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

	typedef enum logic [MODE_W-1:0] {
		MODE_WR_SRC = 2'd0,
		MODE_WR_DST = 2'd1,
		MODE_RD_DST = 2'd2,
		MODE_COPY   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [2:0] shift;
		logic       head_en;
		logic [2:0] head_ofs;
		logic       tail_en;
		logic [2:0] tail_ofs;
	} merge_ctl_t;

endpackage

FILE: src/bcpy_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module bcpy_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/bcpy_merge.sv
// Shift and merge unit that builds one destination byte from two source bytes.
`timescale 1ns / 1ps

module bcpy_merge (
	input  logic [7:0]             prev_byte,
	input  logic [7:0]             cur_byte,
	input  logic [7:0]             dst_byte,
	input  bcpy_pkg::merge_ctl_t   ctl,
	output logic [7:0]             merged
);
	import bcpy_pkg::*;

	logic [15:0]       window;
	logic [BYTE_W-1:0] src_byte;
	logic [BYTE_W-1:0] head_mask;
	logic [BYTE_W-1:0] tail_mask;
	logic [BYTE_W-1:0] mask;

	always_comb begin
		window    = {prev_byte, cur_byte} << ctl.shift;
		src_byte  = window[15:8];
		head_mask = ctl.head_en ? (BYTE_ONES >> ctl.head_ofs) : BYTE_ONES;
		tail_mask = ctl.tail_en ? (BYTE_ONES << (3'd7 - ctl.tail_ofs)) : BYTE_ONES;
		mask      = head_mask & tail_mask;
		merged    = (src_byte & mask) | (dst_byte & ~mask);
	end

endmodule

FILE: src/bit_offset_block_copy.sv
// Top level of the bit offset block copy: stores, sequencer and result register.
// Store writes and refused or empty copies give their result in the cycle after the transfer.
// A destination read goes through the destination RAM read register, then the result register once the output is free.
// A copy primes the source read, then handles one destination byte per cycle through the
// shared merge unit and the destination RAM read-modify-write, then gives its result.
// Reset clears the sequencer and the result valid flag; result data and store contents are undefined.
`timescale 1ns / 1ps

module bit_offset_block_copy (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: byte_addr, byte_data, src_bit_index, dst_bit_index, bit_count.
	input  logic [bcpy_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Fields from bit 0: mode.
	input  logic [bcpy_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: read_byte, status.
	output logic [bcpy_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import bcpy_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RDWAIT = 5'b00010,
		ST_PRIME  = 5'b00100,
		ST_RUN    = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	mode_t              in_mode;
	logic [SADDR_W-1:0] in_addr;
	logic [BYTE_W-1:0]  in_data;
	logic [BIDX_W-1:0]  in_sidx;
	logic [BIDX_W-1:0]  in_didx;
	logic [CNT_W-1:0]   in_cnt;

	logic               acc;
	logic [CNT_W:0]     src_end;
	logic [CNT_W:0]     dst_end;
	logic [CNT_W:0]     dst_last;
	logic               range_err;
	logic [BIDX_W:0]    q0;
	logic [SPTR_W-1:0]  k0;

	logic [SADDR_W-1:0] j_q, j0_q, jlast_q;
	logic [SPTR_W-1:0]  nk_q;
	logic [2:0]         shift_q, hofs_q, tofs_q;
	logic [BYTE_W-1:0]  prev_q;
	logic               src_ok_q;
	logic               last_byte;

	logic               out_valid_q, out_load, out_free;
	logic [BYTE_W-1:0]  rbyte_q, out_rbyte;
	logic               status_q, out_status;

	logic               src_we, src_re;
	logic [SADDR_W-1:0] src_raddr;
	logic [BYTE_W-1:0]  src_rdata, cur_byte;
	logic               dst_we, dst_re;
	logic [SADDR_W-1:0] dst_waddr, dst_raddr;
	logic [BYTE_W-1:0]  dst_wdata, dst_rdata;
	logic               src_issue_ok;
	logic               copy_go;

	merge_ctl_t         mctl;
	logic [BYTE_W-1:0]  merged;

	assign in_mode = mode_t'(s_tuser);
	assign in_addr = s_tdata[DATA_LO-1:ADDR_LO];
	assign in_data = s_tdata[SIDX_LO-1:DATA_LO];
	assign in_sidx = s_tdata[DIDX_LO-1:SIDX_LO];
	assign in_didx = s_tdata[CNT_LO-1:DIDX_LO];
	assign in_cnt  = s_tdata[IN_USED_W-1:CNT_LO];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;

	assign src_end   = {2'b00, in_sidx} + {1'b0, in_cnt};
	assign dst_end   = {2'b00, in_didx} + {1'b0, in_cnt};
	assign dst_last  = dst_end - {{CNT_W{1'b0}}, 1'b1};
	assign range_err = (src_end > (CNT_W+1)'(TOTAL_BITS)) || (dst_end > (CNT_W+1)'(TOTAL_BITS));
	assign q0        = {1'b0, in_sidx} - {{(BIDX_W-2){1'b0}}, in_didx[2:0]};
	assign k0        = {q0[BIDX_W], q0[BIDX_W:3]};
	assign copy_go   = acc && (in_mode == MODE_COPY) && (in_cnt != '0) && !range_err;
	assign last_byte = (j_q == jlast_q);
	assign cur_byte  = src_ok_q ? src_rdata : '0;

	assign mctl.shift    = shift_q;
	assign mctl.head_en  = (j_q == j0_q);
	assign mctl.head_ofs = hofs_q;
	assign mctl.tail_en  = last_byte;
	assign mctl.tail_ofs = tofs_q;

	bcpy_merge u_merge (
		.prev_byte (prev_q),
		.cur_byte  (cur_byte),
		.dst_byte  (dst_rdata),
		.ctl       (mctl),
		.merged    (merged)
	);

	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		out_rbyte    = '0;
		out_status   = 1'b0;
		src_we       = 1'b0;
		src_re       = 1'b0;
		src_raddr    = nk_q[SADDR_W-1:0];
		src_issue_ok = (nk_q[SPTR_W-1:SADDR_W] == '0);
		dst_we       = 1'b0;
		dst_waddr    = in_addr;
		dst_wdata    = in_data;
		dst_re       = 1'b0;
		dst_raddr    = j_q + SADDR_W'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (in_mode)
						MODE_WR_SRC: begin
							src_we   = 1'b1;
							out_load = 1'b1;
						end
						MODE_WR_DST: begin
							dst_we   = 1'b1;
							out_load = 1'b1;
						end
						MODE_RD_DST: begin
							dst_re    = 1'b1;
							dst_raddr = in_addr;
							state_d   = ST_RDWAIT;
						end
						MODE_COPY: begin
							if (copy_go) begin
								src_re       = 1'b1;
								src_raddr    = k0[SADDR_W-1:0];
								src_issue_ok = (k0[SPTR_W-1:SADDR_W] == '0);
								state_d      = ST_PRIME;
							end else begin
								out_load   = 1'b1;
								out_status = (in_cnt != '0) && range_err;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RDWAIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_rbyte = dst_rdata;
					state_d   = ST_IDLE;
				end
			end
			ST_PRIME: begin
				src_re    = 1'b1;
				dst_re    = 1'b1;
				dst_raddr = j_q;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				dst_we    = 1'b1;
				dst_waddr = j_q;
				dst_wdata = merged;
				if (last_byte) begin
					state_d = ST_FIN;
				end else begin
					src_re = 1'b1;
					dst_re = 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rbyte_q  <= out_rbyte;
			status_q <= out_status;
		end
		if (src_re) begin
			src_ok_q <= src_issue_ok;
		end
		if (copy_go) begin
			j_q     <= in_didx[BIDX_W-1:3];
			j0_q    <= in_didx[BIDX_W-1:3];
			jlast_q <= dst_last[BIDX_W-1:3];
			tofs_q  <= dst_last[2:0];
			hofs_q  <= in_didx[2:0];
			shift_q <= q0[2:0];
			nk_q    <= k0 + SPTR_W'(1);
		end else begin
			if (state_q == ST_PRIME) begin
				nk_q   <= nk_q + SPTR_W'(1);
				prev_q <= cur_byte;
			end
			if ((state_q == ST_RUN) && !last_byte) begin
				nk_q   <= nk_q + SPTR_W'(1);
				j_q    <= j_q + SADDR_W'(1);
				prev_q <= cur_byte;
			end
		end
	end

	bcpy_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (in_addr),
		.wdata (in_data),
		.re    (src_re),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	bcpy_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_BYTES)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we),
		.waddr (dst_waddr),
		.wdata (dst_wdata),
		.re    (dst_re),
		.raddr (dst_raddr),
		.rdata (dst_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-BYTE_W-1){1'b0}}, status_q, rbyte_q};

	a_run_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (j_q <= jlast_q))
		else $error("copy walked past its last destination byte");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> m_tready)
		else $error("result register loaded while a result still waits");

	a_copy_primes: assert property (@(posedge clk) disable iff (!arst_n)
		copy_go |=> (state_q == ST_PRIME))
		else $error("accepted copy did not start");

	a_run_follows_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ($past(state_q) == ST_PRIME || $past(state_q) == ST_RUN))
		else $error("copy byte loop entered without priming the source");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the bit offset block copy: store preload, directed table, random mix.
`timescale 1ns / 1ps

module tb;
	import bcpy_pkg::*;

	localparam int N_DIR      = 25;
	localparam int RAND_ITEMS = 700;
	localparam int QUIET_MAX  = 2000;
	localparam int TAIL_WAIT  = 300;

	typedef struct packed {
		mode_t               mode;
		logic [SADDR_W-1:0]  addr;
		logic [BYTE_W-1:0]   data;
		logic [BIDX_W-1:0]   sidx;
		logic [BIDX_W-1:0]   didx;
		logic [CNT_W-1:0]    cnt;
	} xfer_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rd;
		logic              st;
	} reply_t;

	typedef struct packed {
		xfer_t  stim;
		logic   fixed;
		reply_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [MODE_W-1:0]      s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic [BYTE_W-1:0] src_bytes [STORE_BYTES];
	logic [BYTE_W-1:0] dst_bytes [STORE_BYTES];
	reply_t            replies_due [$];

	int        err_count   = 0;
	int        n_in        = 0;
	int        n_out       = 0;
	int        n_copy      = 0;
	int        n_refused   = 0;
	int        n_read      = 0;
	int        burst_left  = 0;
	int        quiet_cycles = 0;
	logic [4:0]  win_cnt   = '0;
	logic [15:0] stall_pat = '0;
	logic        free_run  = 1'b0;

	dir_row_t dir_tab [N_DIR];

	bit_offset_block_copy uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic reply_t apply_to_stores(input xfer_t it);
		reply_t r;
		int     sp;
		int     dp;
		int     k;
		r = '0;
		case (it.mode)
			MODE_WR_SRC: src_bytes[it.addr] = it.data;
			MODE_WR_DST: dst_bytes[it.addr] = it.data;
			MODE_RD_DST: r.rd = dst_bytes[it.addr];
			MODE_COPY: begin
				if (it.cnt != 0) begin
					if (int'(it.sidx) + int'(it.cnt) > TOTAL_BITS ||
					    int'(it.didx) + int'(it.cnt) > TOTAL_BITS) begin
						r.st = 1'b1;
					end else begin
						for (k = 0; k < int'(it.cnt); k++) begin
							sp = int'(it.sidx) + k;
							dp = int'(it.didx) + k;
							dst_bytes[dp / 8][7 - dp % 8] = src_bytes[sp / 8][7 - sp % 8];
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic xfer_t random_xfer();
		xfer_t it;
		int    pick;
		int    sub;
		int    len;
		it.addr = SADDR_W'($urandom);
		it.data = BYTE_W'($urandom);
		it.sidx = BIDX_W'($urandom);
		it.didx = BIDX_W'($urandom);
		it.cnt  = CNT_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it.mode = MODE_WR_SRC;
		end else if (pick < 35) begin
			it.mode = MODE_WR_DST;
		end else if (pick < 60) begin
			it.mode = MODE_RD_DST;
		end else begin
			it.mode = MODE_COPY;
			sub = $urandom_range(0, 99);
			if (sub < 4) begin
				it.cnt = '0;
			end else if (sub >= 14) begin
				if (sub < 70)
					len = $urandom_range(1, 24);
				else if (sub < 93)
					len = $urandom_range(25, 300);
				else
					len = $urandom_range(301, TOTAL_BITS);
				it.cnt  = CNT_W'(len);
				it.sidx = BIDX_W'($urandom_range(0, TOTAL_BITS - len));
				it.didx = BIDX_W'($urandom_range(0, TOTAL_BITS - len));
				if ($urandom_range(0, 9) == 0)
					it.sidx = BIDX_W'(TOTAL_BITS - len);
				if ($urandom_range(0, 9) == 0)
					it.didx = BIDX_W'(TOTAL_BITS - len);
			end
		end
		return it;
	endfunction

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("tb: mismatch: %s", msg);
	endtask

	task automatic send_xfer(input xfer_t it, input logic fixed, input reply_t fixed_reply);
		int     gap;
		reply_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= IN_TDATA_W'({it.cnt, it.didx, it.sidx, it.data, it.addr});
		do @(posedge clk); while (!s_tready);
		burst_left--;
		want = apply_to_stores(it);
		if (fixed)
			want = fixed_reply;
		replies_due.push_back(want);
		n_in++;
		if (it.mode == MODE_RD_DST)
			n_read++;
		if (it.mode == MODE_COPY) begin
			n_copy++;
			if (want.st)
				n_refused++;
		end
	endtask

	always @(posedge clk) begin
		win_cnt <= win_cnt + 1'b1;
		if (win_cnt == '0) begin
			stall_pat <= 16'($urandom);
			free_run  <= ($urandom_range(0, 3) == 0);
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
		m_tready <= free_run | stall_pat[0];
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_out++;
			if (replies_due.size() == 0) begin
				note_error($sformatf("unexpected result %04h", m_tdata));
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[7:0] !== want.rd || m_tdata[8] !== want.st ||
				    m_tdata[15:9] !== '0)
					note_error($sformatf(
						"result %0d: expected read_byte %02h status %0d, got %02h %0d pad %02h",
						n_out, want.rd, want.st, m_tdata[7:0], m_tdata[8], m_tdata[15:9]));
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_MAX)
			@(posedge clk);
		$display("tb: no transfer for %0d cycles", QUIET_MAX);
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		xfer_t it;
		int    a;
		int    n;
		dir_tab = '{
			'{'{MODE_WR_SRC, 8'd0,   8'hff, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_SRC, 8'd255, 8'h00, 11'h7ff, 11'h7ff, 12'hfff}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_SRC, 8'd128, 8'h80, 11'h155, 11'h2aa, 12'h555}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_DST, 8'd0,   8'h00, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_DST, 8'd255, 8'hff, 11'h7ff, 11'h7ff, 12'hfff}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_DST, 8'd1,   8'h7f, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_WR_DST, 8'd2,   8'hfe, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_RD_DST, 8'd0,   8'hff, 11'h7ff, 11'h7ff, 12'hfff}, 1'b1, '{8'h00, 1'b0}},
			'{'{MODE_RD_DST, 8'd255, 8'h00, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'hff, 1'b0}},
			'{'{MODE_RD_DST, 8'd1,   8'h00, 11'h000, 11'h000, 12'h000}, 1'b1, '{8'h7f, 1'b0}},
			'{'{MODE_COPY,   8'd255, 8'hff, 11'h7ff, 11'h7ff, 12'd0},   1'b1, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd0,    11'd0,    12'd2048}, 1'b0, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd1,    11'd0,    12'd2048}, 1'b1, '{8'h00, 1'b1}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd0,    11'd1,    12'd2048}, 1'b1, '{8'h00, 1'b1}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd2047, 11'd0,    12'd1},    1'b0, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd2047, 11'd0,    12'd2},    1'b1, '{8'h00, 1'b1}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd0,    11'd2047, 12'd2},    1'b1, '{8'h00, 1'b1}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd0,    11'd2047, 12'd1},    1'b0, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd0,    11'd0,    12'hfff},  1'b1, '{8'h00, 1'b1}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd3,    11'd5,    12'd13},   1'b0, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd10,   11'd9,    12'd5},    1'b0, '{8'h00, 1'b0}},
			'{'{MODE_COPY,   8'd0,   8'h00, 11'd100,  11'd7,    12'd1021}, 1'b0, '{8'h00, 1'b0}},
			'{'{MODE_RD_DST, 8'd0,   8'h00, 11'h000, 11'h000, 12'h000}, 1'b0, '{8'h00, 1'b0}},
			'{'{MODE_RD_DST, 8'd255, 8'h00, 11'h000, 11'h000, 12'h000}, 1'b0, '{8'h00, 1'b0}},
			'{'{MODE_RD_DST, 8'd2,   8'h00, 11'h000, 11'h000, 12'h000}, 1'b0, '{8'h00, 1'b0}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every byte of both stores is defined before anything reads or copies from them.
		for (a = 0; a < STORE_BYTES; a++) begin
			it = random_xfer();
			it.mode = MODE_WR_SRC;
			it.addr = SADDR_W'(a);
			send_xfer(it, 1'b0, '0);
			it = random_xfer();
			it.mode = MODE_WR_DST;
			it.addr = SADDR_W'(a);
			send_xfer(it, 1'b0, '0);
		end

		for (n = 0; n < N_DIR; n++)
			send_xfer(dir_tab[n].stim, dir_tab[n].fixed, dir_tab[n].want);

		for (n = 0; n < RAND_ITEMS; n++)
			send_xfer(random_xfer(), 1'b0, '0);

		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (replies_due.size() != 0)
			note_error($sformatf("%0d results never arrived", replies_due.size()));

		$display("tb: %0d transfers in, %0d results out, %0d reads", n_in, n_out, n_read);
		$display("tb: %0d copies, %0d refused for range, %0d mismatches",
			n_copy, n_refused, err_count);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/bcpy_pkg.sv
src/bcpy_ram.sv
src/bcpy_merge.sv
src/bit_offset_block_copy.sv
verif/tb.sv
